// ----- rtl/cbirq_pkg.sv -----
// Shared constants and types for the cartridge bank and IRQ register block.
// Holds the write decode groups, IRQ control bit positions and the result record.
// No dependencies.
`default_nettype none

package cbirq_pkg;

    // item kinds
    localparam logic OpWrite = 1'b0;
    localparam logic OpDots  = 1'b1;

    // address bits 15..12 of a register write
    localparam logic [3:0] GrpPrg    = 4'h8;
    localparam logic [3:0] GrpPrgHi  = 4'h9;
    localparam logic [3:0] GrpChr0   = 4'hA;
    localparam logic [3:0] GrpChr1   = 4'hB;
    localparam logic [3:0] GrpChr2   = 4'hC;
    localparam logic [3:0] GrpChr3   = 4'hD;
    localparam logic [3:0] GrpMisc   = 4'hE;
    localparam logic [3:0] GrpIrq    = 4'hF;

    // address bits that pick the second register of a pair
    localparam logic [15:0] SecondRegMask = 16'h0018;

    // irq control bit positions
    localparam int CtrlAckEn = 0;
    localparam int CtrlEn    = 1;
    localparam int CtrlCycle = 2;
    localparam logic [2:0] CtrlMask = 3'h7;

    // dot and scanline timing
    localparam logic [2:0] CpuDots      = 3'd3;
    localparam logic [8:0] ScanlineDots = 9'd341;
    localparam logic [7:0] CountTop     = 8'hFF;

    // one result record
    typedef struct packed {
        logic [7:0] prg_bank_8000;
        logic [7:0] prg_bank_a000;
        logic [7:0] prg_bank_c000;
        logic [7:0] chr_bank_selected;
        logic [1:0] mirror_mode;
        logic       irq_line;
        logic [7:0] irq_count_now;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/cartridge_bank_and_irq_registers_core.sv -----
// Top level of the cartridge bank and IRQ register block.
// Uses cbirq_pkg for decode groups, timing constants and the result record.
// Holds the input register, the register file, the IRQ counter and the result register.
`default_nettype none

// One item per clock cycle sustained while the result channel is not stalled. An
// item is taken into an input register, its write or dot update runs through one
// stage of logic into the bank and IRQ registers, and its result appears in the
// result register when the item leaves the input register, which waits while a
// stalled result is held. The result register and the input register each hold
// one item, so a new item is taken while a result waits if the input register is empty.
// An item of up to three dots makes at most one CPU cycle for the IRQ counter.
module cartridge_bank_and_irq_registers_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_value,
    input  wire logic [1:0]  i_dots,
    input  wire logic [2:0]  i_chr_query,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_prg_bank_8000,
    output logic [7:0]       o_prg_bank_a000,
    output logic [7:0]       o_prg_bank_c000,
    output logic [7:0]       o_chr_bank_selected,
    output logic [1:0]       o_mirror_mode,
    output logic             o_irq_line,
    output logic [7:0]       o_irq_count_now
);

    // input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_value;
    logic [1:0]  r_in_dots;
    logic [2:0]  r_in_query;

    // register file and irq state
    logic [7:0] r_prg [3];
    logic [7:0] r_chr [8];
    logic [1:0] r_mirror;
    logic [7:0] r_reload;
    logic [7:0] r_irq_count;
    logic [2:0] r_ctrl;
    logic [8:0] r_prescaler;
    logic       r_irq_flag;
    logic [1:0] r_dot_acc;

    // result register
    logic                 r_out_valid;
    cbirq_pkg::t_result   r_res;

    // next values
    logic [7:0] n_prg [3];
    logic [7:0] n_chr [8];
    logic [1:0] n_mirror;
    logic [7:0] n_reload;
    logic [7:0] n_irq_count;
    logic [2:0] n_ctrl;
    logic [8:0] n_prescaler;
    logic       n_irq_flag;
    logic [1:0] n_dot_acc;
    cbirq_pkg::t_result n_res;

    logic       adv;
    logic       in_ready;
    logic       second;
    logic [3:0] grp;
    logic [1:0] chr_pair;
    logic [2:0] acc_sum;
    logic       cpu_cyc;
    logic [8:0] pre_sum;
    logic       tick;

    // handshake: the input register moves on when the result register is free or its result is taken
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_ready   = !r_in_valid || adv;
    assign o_in_stall = !in_ready;

    // write decode fields
    assign second   = (r_in_addr & cbirq_pkg::SecondRegMask) != 16'h0000;
    assign grp      = r_in_addr[15:12];
    assign chr_pair = 2'(grp - cbirq_pkg::GrpChr0);

    // dot accumulation, at most one cpu cycle per item
    assign acc_sum = {1'b0, r_in_dots} + {1'b0, r_dot_acc};
    assign cpu_cyc = acc_sum >= cbirq_pkg::CpuDots;
    assign pre_sum = r_prescaler + {6'd0, cbirq_pkg::CpuDots};

    // state update for one item
    always_comb begin
        n_prg       = r_prg;
        n_chr       = r_chr;
        n_mirror    = r_mirror;
        n_reload    = r_reload;
        n_irq_count = r_irq_count;
        n_ctrl      = r_ctrl;
        n_prescaler = r_prescaler;
        n_irq_flag  = r_irq_flag;
        n_dot_acc   = r_dot_acc;
        tick        = 1'b0;
        if (r_in_op == cbirq_pkg::OpWrite) begin
            if (r_in_addr[15]) begin
                case (grp)
                    cbirq_pkg::GrpPrg: begin
                        if (second) begin
                            n_prg[1] = r_in_value;
                        end else begin
                            n_prg[0] = r_in_value;
                        end
                    end
                    cbirq_pkg::GrpPrgHi: begin
                        if (!second) begin
                            n_prg[2] = r_in_value;
                        end
                    end
                    cbirq_pkg::GrpChr0, cbirq_pkg::GrpChr1,
                    cbirq_pkg::GrpChr2, cbirq_pkg::GrpChr3: begin
                        n_chr[{chr_pair, second}] = r_in_value;
                    end
                    cbirq_pkg::GrpMisc: begin
                        if (second) begin
                            n_reload = r_in_value;
                        end else begin
                            n_mirror = r_in_value[1:0];
                        end
                    end
                    cbirq_pkg::GrpIrq: begin
                        n_irq_flag = 1'b0;
                        if (second) begin
                            // acknowledge: enable follows enable-after-ack
                            n_ctrl[cbirq_pkg::CtrlEn] = r_ctrl[cbirq_pkg::CtrlAckEn];
                        end else begin
                            n_ctrl = r_in_value[2:0] & cbirq_pkg::CtrlMask;
                            if (r_in_value[cbirq_pkg::CtrlEn]) begin
                                n_prescaler = 9'd0;
                                n_irq_count = r_reload;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            n_dot_acc = cpu_cyc ? 2'(acc_sum - cbirq_pkg::CpuDots) : acc_sum[1:0];
            if (cpu_cyc && r_ctrl[cbirq_pkg::CtrlEn]) begin
                if (r_ctrl[cbirq_pkg::CtrlCycle]) begin
                    tick = 1'b1;
                end else if (pre_sum >= cbirq_pkg::ScanlineDots) begin
                    n_prescaler = pre_sum - cbirq_pkg::ScanlineDots;
                    tick        = 1'b1;
                end else begin
                    n_prescaler = pre_sum;
                end
            end
            // counter step, reload and raise on overflow
            if (tick) begin
                if (r_irq_count == cbirq_pkg::CountTop) begin
                    n_irq_count = r_reload;
                    n_irq_flag  = 1'b1;
                end else begin
                    n_irq_count = r_irq_count + 8'd1;
                end
            end
        end
    end

    // result from the updated state
    always_comb begin
        n_res.prg_bank_8000     = n_prg[0];
        n_res.prg_bank_a000     = n_prg[1];
        n_res.prg_bank_c000     = n_prg[2];
        n_res.chr_bank_selected = n_chr[r_in_query];
        n_res.mirror_mode       = n_mirror;
        n_res.irq_line          = n_irq_flag;
        n_res.irq_count_now     = n_irq_count;
    end

    // input register and transfer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_op    <= i_operation;
            r_in_addr  <= i_address;
            r_in_value <= i_value;
            r_in_dots  <= i_dots;
            r_in_query <= i_chr_query;
        end
    end

    // bank and irq state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg       <= '{default: 8'd0};
            r_chr       <= '{default: 8'd0};
            r_mirror    <= 2'd0;
            r_reload    <= 8'd0;
            r_irq_count <= 8'd0;
            r_ctrl      <= 3'd0;
            r_prescaler <= 9'd0;
            r_irq_flag  <= 1'b0;
            r_dot_acc   <= 2'd0;
        end else if (adv) begin
            r_prg       <= n_prg;
            r_chr       <= n_chr;
            r_mirror    <= n_mirror;
            r_reload    <= n_reload;
            r_irq_count <= n_irq_count;
            r_ctrl      <= n_ctrl;
            r_prescaler <= n_prescaler;
            r_irq_flag  <= n_irq_flag;
            r_dot_acc   <= n_dot_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_prg_bank_8000     = r_res.prg_bank_8000;
    assign o_prg_bank_a000     = r_res.prg_bank_a000;
    assign o_prg_bank_c000     = r_res.prg_bank_c000;
    assign o_chr_bank_selected = r_res.chr_bank_selected;
    assign o_mirror_mode       = r_res.mirror_mode;
    assign o_irq_line          = r_res.irq_line;
    assign o_irq_count_now     = r_res.irq_count_now;

    // the irq line is only raised by a dot transfer
    a_flag_from_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_flag) |-> $past(adv && r_in_op == cbirq_pkg::OpDots))
        else $error("irq flag raised without a dot transfer");

    // leftover dots never make a whole cpu cycle
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot_acc < 2'd3)
        else $error("dot accumulator out of range");

    // prescaler always stays within one scanline
    a_pre_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prescaler < cbirq_pkg::ScanlineDots)
        else $error("prescaler out of range");

    // state only changes when an item moves into the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_irq_count) && $stable(r_ctrl) && $stable(r_irq_flag))
        else $error("irq state changed without a transfer");

endmodule

`default_nettype wire
